@@ sv/tpr90_pkg.sv @@
// Shared types, constants and the pixel rotation function of the tiled plane rotator.
// No dependencies; used by tpr90_emit and tiled_plane_rotate_90_core.
`default_nettype none

package tpr90_pkg;

    localparam int TILE         = 8;
    localparam int DATA_W       = 64;
    localparam int ADDR_W       = 24;
    localparam int CFG_W        = 13;
    localparam int CFG_IDX_W    = 2;
    localparam int MAX_SIDE_DEF = 4096;

    localparam logic [2:0] ROW_LAST = 3'd7;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_DST_WIDTH   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DEST_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TURN_DIR    = 2'd2;

    // turn directions
    localparam logic DIR_CW  = 1'b0;
    localparam logic DIR_CCW = 1'b1;

    // eight rows of a tile, row r at index r
    typedef logic [TILE-1:0][DATA_W-1:0] t_tile;

    // one finished tile handed to the emitter
    typedef struct packed {
        t_tile             tile;
        logic [ADDR_W-1:0] base;
        logic [ADDR_W-1:0] step;
        logic              dir;
        logic              frame_last;
    } t_job;

    // destination row i of a rotated tile
    function automatic logic [DATA_W-1:0] rotate_row(input t_tile tile, input logic [2:0] i,
                                                     input logic dir);
        logic [DATA_W-1:0] v;
        v = '0;
        for (int k = 0; k < TILE; k++) begin
            if (dir == DIR_CW) begin
                v[8*k +: 8] = tile[TILE-1-k][{i, 3'b000} +: 8];
            end else begin
                v[8*k +: 8] = tile[k][{~i, 3'b000} +: 8];
            end
        end
        return v;
    endfunction

endpackage

`default_nettype wire

@@ sv/tpr90_emit.sv @@
// Output stage: holds one rotated tile and plays out its eight rows with addresses.
// Depends on tpr90_pkg.
`default_nettype none

module tpr90_emit (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_load,
    input  wire tpr90_pkg::t_job            i_job,
    output logic                            o_free,
    output logic                            o_valid,
    input  wire logic                       i_ready,
    output logic [tpr90_pkg::DATA_W-1:0]    o_bytes,
    output logic [tpr90_pkg::ADDR_W-1:0]    o_addr,
    output logic                            o_tile_last,
    output logic                            o_frame_last
);

    logic                         r_valid;
    logic [2:0]                   r_idx;
    tpr90_pkg::t_job              r_job;
    logic [tpr90_pkg::ADDR_W-1:0] r_addr;
    logic                         xfer;
    logic                         at_last;

    assign at_last = (r_idx == tpr90_pkg::ROW_LAST);
    assign xfer    = r_valid && i_ready;
    // free when empty or when the final row leaves this cycle
    assign o_free  = !r_valid || (at_last && i_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= '0;
        end else if (i_load) begin
            r_valid <= 1'b1;
            r_idx   <= '0;
        end else if (xfer) begin
            if (at_last) begin
                r_valid <= 1'b0;
            end
            r_idx <= r_idx + 3'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_job  <= i_job;
            r_addr <= i_job.base;
        end else if (xfer) begin
            r_addr <= r_addr + r_job.step;
        end
    end

    assign o_valid      = r_valid;
    assign o_bytes      = tpr90_pkg::rotate_row(r_job.tile, r_idx, r_job.dir);
    assign o_addr       = r_addr;
    assign o_tile_last  = at_last;
    assign o_frame_last = at_last && r_job.frame_last;

endmodule

`default_nettype wire

@@ sv/tiled_plane_rotate_90_core.sv @@
// Top level of the tiled quarter-turn plane rotator: tile fill, address stage, emitter.
// Depends on tpr90_pkg and tpr90_emit.
//
// Usage:
//   Slave stream: one 64-bit source tile row per transfer; eight rows make a tile,
//   tiles in source order. Master stream: eight rotated destination rows per tile,
//   tdata = {dest_address, out_bytes}, tlast = tile_last, tuser = frame_last.
//   Config port: write destination width, height and turn direction only while idle.
// Path: a tile's eighth row enters the address stage register; the tile is loaded
//   into the emitter once the emitter is free, and its first rotated row is then valid.
// Throughput: one row per cycle on each side while the master side is ready; set by the
//   emitter, which sends one destination row per cycle and overlaps the next tile's fill.
// Reset: counters return to the first tile of the frame, registers to 8 / 8 /
//   clockwise, all pipeline stages empty.
// Stall: with the master side stalled, the fill keeps taking rows up to the
//   eighth row of the next tile; that row waits while the address stage is full.
`default_nettype none

module tiled_plane_rotate_90_core #(
    parameter int MAX_SIDE = tpr90_pkg::MAX_SIDE_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    // configuration write port
    input  wire logic                          i_cfg_we,
    input  wire logic [tpr90_pkg::CFG_IDX_W-1:0] i_cfg_addr,
    input  wire logic [tpr90_pkg::CFG_W-1:0]   i_cfg_wdata,
    // source rows
    input  wire logic                          i_s_axis_tvalid,
    output logic                               o_s_axis_tready,
    input  wire logic [63:0]                   i_s_axis_tdata,  // [63:0] row_bytes
    // rotated rows
    output logic                               o_m_axis_tvalid,
    input  wire logic                          i_m_axis_tready,
    output logic [87:0]                        o_m_axis_tdata,  // [63:0] out_bytes,
                                                                // [87:64] dest_address
    output logic                               o_m_axis_tlast,  // tile_last
    output logic                               o_m_axis_tuser   // [0] frame_last
);

    localparam int MAX_T = MAX_SIDE / tpr90_pkg::TILE;   // tiles per side, max
    localparam int CW    = $clog2(MAX_T);                 // tile counter width
    localparam int TW    = CW + 1;                        // tile count width
    localparam int AW    = tpr90_pkg::ADDR_W;
    localparam int RAW_W = tpr90_pkg::CFG_W - 3;

    // ---------------- configuration registers ----------------
    logic [tpr90_pkg::CFG_W-1:0] r_dst_width;
    logic [tpr90_pkg::CFG_W-1:0] r_dest_height;
    logic                        r_turn;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dst_width   <= tpr90_pkg::CFG_W'(8);
            r_dest_height <= tpr90_pkg::CFG_W'(8);
            r_turn        <= tpr90_pkg::DIR_CW;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                tpr90_pkg::CFG_DST_WIDTH:   r_dst_width   <= i_cfg_wdata;
                tpr90_pkg::CFG_DEST_HEIGHT: r_dest_height <= i_cfg_wdata;
                tpr90_pkg::CFG_TURN_DIR:    r_turn        <= i_cfg_wdata[0];
                default: ;  // unmapped index, ignored
            endcase
        end
    end

    // sizes in tiles: low three bits dropped, clamped to 1..MAX_T
    logic [RAW_W-1:0] w_raw, h_raw;
    logic [TW-1:0]    wt, ht;

    assign w_raw = r_dst_width[tpr90_pkg::CFG_W-1:3];
    assign h_raw = r_dest_height[tpr90_pkg::CFG_W-1:3];

    always_comb begin
        if (w_raw == '0)             wt = TW'(1);
        else if (32'(w_raw) > MAX_T) wt = TW'(MAX_T);
        else                         wt = TW'(w_raw);
        if (h_raw == '0)             ht = TW'(1);
        else if (32'(h_raw) > MAX_T) ht = TW'(MAX_T);
        else                         ht = TW'(h_raw);
    end

    // ---------------- tile fill ----------------
    logic [tpr90_pkg::DATA_W-1:0] r_fill [0:tpr90_pkg::TILE-2];
    logic [2:0]    r_row;
    logic [CW-1:0] r_tx, r_ty;        // source tile column / row counters
    logic          in_acc, tile_done;
    logic          last_col, last_row;
    logic [CW-1:0] n_tx, n_ty;

    // address stage
    logic                 r_b_valid;
    tpr90_pkg::t_tile     r_b_tile;
    logic [CW-1:0]        r_b_tx, r_b_ty;
    logic                 r_b_flast;
    logic                 b_move, b_free;

    // emitter
    logic                 c_free;
    tpr90_pkg::t_job      job;

    assign b_move          = r_b_valid && c_free;
    assign b_free          = !r_b_valid || c_free;
    assign o_s_axis_tready = (r_row != tpr90_pkg::ROW_LAST) || b_free;
    assign in_acc          = i_s_axis_tvalid && o_s_axis_tready;
    assign tile_done       = in_acc && (r_row == tpr90_pkg::ROW_LAST);

    assign last_col = (TW'(r_tx) + TW'(1)) >= ht;
    assign last_row = (TW'(r_ty) + TW'(1)) >= wt;

    always_comb begin
        n_tx = r_tx;
        n_ty = r_ty;
        if (last_col) begin
            n_tx = '0;
            n_ty = last_row ? '0 : r_ty + CW'(1);
        end else begin
            n_tx = r_tx + CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row <= '0;
            r_tx  <= '0;
            r_ty  <= '0;
        end else if (in_acc) begin
            r_row <= r_row + 3'd1;   // wraps after the eighth row
            if (tile_done) begin
                r_tx <= n_tx;
                r_ty <= n_ty;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc && !tile_done) begin
            r_fill[r_row] <= i_s_axis_tdata;
        end
    end

    // ---------------- address stage ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else if (tile_done) begin
            r_b_valid <= 1'b1;
        end else if (b_move) begin
            r_b_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (tile_done) begin
            r_b_tile  <= {i_s_axis_tdata, r_fill[6], r_fill[5], r_fill[4],
                          r_fill[3], r_fill[2], r_fill[1], r_fill[0]};
            r_b_tx    <= r_tx;
            r_b_ty    <= r_ty;
            r_b_flast <= last_col && last_row;
        end
    end

    // base = W*m + c, mod 2^24
    //   clockwise:     m = 8*tx + 1,          c = -8 - 8*ty
    //   anticlockwise: m = 8*(ht - 1 - tx),   c = 8*ty
    // W = 8*wt, so only the low 21 bits of wt*m matter.
    logic [AW-4:0]    m_val, diff;
    logic [TW+AW-4:0] prod;
    logic [AW-1:0]    wm, c_val, ty8, n_base;

    always_comb begin
        diff = (AW-3)'(ht) - (AW-3)'(1) - (AW-3)'(r_b_tx);
        if (r_turn == tpr90_pkg::DIR_CW) begin
            m_val = {(AW-6)'(r_b_tx), 3'b000} + (AW-3)'(1);
        end else begin
            m_val = {diff[AW-7:0], 3'b000};
        end
        prod  = (TW+AW-3)'(wt) * (TW+AW-3)'(m_val);
        wm    = {prod[AW-4:0], 3'b000};
        ty8   = {(AW-3)'(r_b_ty), 3'b000};
        if (r_turn == tpr90_pkg::DIR_CW) begin
            c_val = AW'(0) - AW'(8) - ty8;
        end else begin
            c_val = ty8;
        end
        n_base = wm + c_val;
    end

    always_comb begin
        job.tile       = r_b_tile;
        job.base       = n_base;
        job.step       = {(AW-3)'(wt), 3'b000};
        job.dir        = r_turn;
        job.frame_last = r_b_flast;
    end

    // ---------------- emitter ----------------
    logic [tpr90_pkg::DATA_W-1:0] out_bytes;
    logic [AW-1:0]                out_addr;

    tpr90_emit u_emit (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_load       (b_move),
        .i_job        (job),
        .o_free       (c_free),
        .o_valid      (o_m_axis_tvalid),
        .i_ready      (i_m_axis_tready),
        .o_bytes      (out_bytes),
        .o_addr       (out_addr),
        .o_tile_last  (o_m_axis_tlast),
        .o_frame_last (o_m_axis_tuser)
    );

    assign o_m_axis_tdata = {out_addr, out_bytes};

    // ---------------- assertions ----------------
    a_tile_to_stage: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        tile_done |=> r_b_valid)
        else $error("completed tile did not reach the address stage");

    a_row_wrap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        tile_done |=> (r_row == '0))
        else $error("row counter did not wrap after the eighth row");

    a_stage_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_b_valid && !c_free) |=> (r_b_valid && $stable(r_b_tx) && $stable(r_b_ty)))
        else $error("address stage lost a waiting tile");

    a_emit_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        b_move |=> (o_m_axis_tvalid && !o_m_axis_tlast))
        else $error("emitter did not start at the first row of a tile");

endmodule

`default_nettype wire

@@ tb/tb_tiled_plane_rotate_90_core.sv @@
// Self-checking testbench for tiled_plane_rotate_90_core: source tile rows in, rotated rows out.
// Depends on tpr90_pkg and the core; the golden rotation and address math live in this file.
`timescale 1ns / 1ps

module tb_tiled_plane_rotate_90_core;
    import tpr90_pkg::*;

    localparam int CYCLE_LIMIT   = 200000;
    localparam int RANDOM_ROWS   = 256;
    localparam int HOLD_CYCLES   = 300;  // long sink back-pressure, fills the core
    localparam int SETTLE_CYCLES = 8;    // pad after the core drains, before a config write

    // index with no register behind it, writes must be ignored
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

    typedef enum logic [1:0] {FILL_ZERO, FILL_ONES, FILL_RAMP, FILL_RAND} t_fill;

    // one destination row as it leaves the core
    typedef struct packed {
        logic [DATA_W-1:0] pix;
        logic [ADDR_W-1:0] addr;
        logic              tile_last;
        logic              frame_last;
    } t_rot_row;

    // one run of the directed opening; pin_* fields hold a result readable by eye
    typedef struct packed {
        bit                set_geo;
        logic [CFG_W-1:0]  width;
        logic [CFG_W-1:0]  height;
        logic              dir;
        int                rows;
        t_fill             fill;
        bit                pinned;
        logic [DATA_W-1:0] pin_pix;
        logic [ADDR_W-1:0] pin_base;
        logic [ADDR_W-1:0] pin_step;
        bit                pin_frame_last;
    } t_opening_run;

    // Directed opening, 24 rows in all:
    //  - all-ones tile straight after reset, 8x8 clockwise: addresses 0..56, frame ends
    //  - all-zero tile, width 0 (floors to one tile), height 8191 (caps at 4096),
    //    anticlockwise: first row at 8*(4096-8), frame not done
    //  - three ramp rows clockwise, then the rest of that tile anticlockwise with
    //    13x15 (low bits dropped, one tile): direction flips mid-tile, the column
    //    counter sits past the new height so the address wraps below zero
    localparam t_opening_run OPENING_RUNS [4] = '{
        // set   width     height    dir      n  fill       pin   pix / base / step / frame
        '{1'b0, 13'd8,    13'd8,    DIR_CW,  8, FILL_ONES, 1'b1, 64'hFFFF_FFFF_FFFF_FFFF,
          24'd0, 24'd8, 1'b1},
        '{1'b1, 13'd0,    13'd8191, DIR_CCW, 8, FILL_ZERO, 1'b1, 64'h0,
          24'd32704, 24'd8, 1'b0},
        '{1'b1, 13'd0,    13'd8191, DIR_CW,  3, FILL_RAMP, 1'b0, 64'h0, 24'd0, 24'd0, 1'b0},
        '{1'b1, 13'd13,   13'd15,   DIR_CCW, 5, FILL_RAND, 1'b0, 64'h0, 24'd0, 24'd0, 1'b0}
    };

    // clock and core ports
    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_addr;
    logic [CFG_W-1:0]     i_cfg_wdata;
    logic                 i_s_axis_tvalid;
    logic                 o_s_axis_tready;
    logic [63:0]          i_s_axis_tdata;   // [63:0] row_bytes
    logic                 o_m_axis_tvalid;
    logic                 i_m_axis_tready;
    logic [87:0]          o_m_axis_tdata;   // [63:0] out_bytes, [87:64] dest_address
    logic                 o_m_axis_tlast;   // tile_last
    logic                 o_m_axis_tuser;   // [0] frame_last

    // source rows waiting to be sent; the head is what the source offers
    logic [DATA_W-1:0] source_q [$];
    // rotated rows predicted but not yet seen on the output
    t_rot_row          rotated_q [$];

    // golden copy of the core state
    logic [CFG_W-1:0]  geo_width  = 13'd8;
    logic [CFG_W-1:0]  geo_height = 13'd8;
    logic              geo_dir    = DIR_CW;
    logic [DATA_W-1:0] tile_rows [TILE];
    logic [2:0]        fill_row     = '0;
    int unsigned       src_tile_col = 0;
    int unsigned       src_tile_row = 0;

    // pinned expectation for the tile that completes during a directed run
    bit                pinned_en = 1'b0;
    logic [DATA_W-1:0] pinned_pix;
    logic [ADDR_W-1:0] pinned_base;
    logic [ADDR_W-1:0] pinned_step;
    bit                pinned_frame_last;

    bit row_fire      = 1'b0;  // source transfer seen at the last rising edge
    bit long_hold_req = 1'b0;
    int mismatches    = 0;
    int cycle_cnt     = 0;

    tiled_plane_rotate_90_core dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_addr      (i_cfg_addr),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tlast  (o_m_axis_tlast),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // tiles per side: low three bits dropped, at least one tile, capped at MAX_SIDE
    function automatic int unsigned tiles_across(input logic [CFG_W-1:0] side);
        int unsigned t;
        t = side / TILE;
        if (t == 0) t = 1;
        if (t > MAX_SIDE_DEF / TILE) t = MAX_SIDE_DEF / TILE;
        return t;
    endfunction

    // Store one source row; on the eighth row of a tile, queue its eight rotated rows.
    function automatic void take_source_row(input logic [DATA_W-1:0] row);
        int unsigned wt;
        int unsigned ht;
        logic [63:0] w;
        logic [63:0] h;
        logic [63:0] ty;
        logic [63:0] tx;
        logic [63:0] base;
        bit          last_col;
        bit          last_row;
        t_rot_row    r;
        tile_rows[fill_row] = row;
        if (fill_row != ROW_LAST) begin
            fill_row = fill_row + 3'd1;
            return;
        end
        fill_row = '0;
        wt = tiles_across(geo_width);
        ht = tiles_across(geo_height);
        w  = 64'(wt) * 64'd8;
        h  = 64'(ht) * 64'd8;
        ty = 64'(src_tile_row);
        tx = 64'(src_tile_col);
        // source columns run down the destination height, source rows across its width
        last_col = (tx + 64'd1 >= 64'(ht));
        last_row = (ty + 64'd1 >= 64'(wt));
        // 64-bit math, truncated to 24 bits per row: covers negative bases after a resize
        if (geo_dir == DIR_CW) base = (w - 64'd8) - 64'd8 * ty + 64'd8 * tx * w;
        else                   base = w * (h - 64'd8) + 64'd8 * ty - 64'd8 * tx * w;
        for (int i = 0; i < TILE; i++) begin
            for (int k = 0; k < TILE; k++) begin
                if (geo_dir == DIR_CW) r.pix[8*k +: 8] = tile_rows[TILE-1-k][8*i +: 8];
                else                   r.pix[8*k +: 8] = tile_rows[k][8*(TILE-1-i) +: 8];
            end
            r.addr       = 24'(base + 64'(i) * w);
            r.tile_last  = (i == TILE - 1);
            r.frame_last = (i == TILE - 1) && last_col && last_row;
            if (pinned_en) begin
                r.pix        = pinned_pix;
                r.addr       = pinned_base + 24'(i) * pinned_step;
                r.frame_last = (i == TILE - 1) && pinned_frame_last;
            end
            rotated_q.push_back(r);
        end
        if (last_col) begin
            src_tile_col = 0;
            src_tile_row = last_row ? 0 : src_tile_row + 1;
        end else begin
            src_tile_col = src_tile_col + 1;
        end
    endfunction

    function automatic void check_rotated_row();
        t_rot_row want;
        if (rotated_q.size() == 0) begin
            $error("unexpected rotated row, dest_address %h", o_m_axis_tdata[87:64]);
            mismatches++;
            return;
        end
        want = rotated_q.pop_front();
        if (o_m_axis_tdata[63:0] !== want.pix) begin
            $error("out_bytes: expected %h, got %h", want.pix, o_m_axis_tdata[63:0]);
            mismatches++;
        end
        if (o_m_axis_tdata[87:64] !== want.addr) begin
            $error("dest_address: expected %h, got %h", want.addr, o_m_axis_tdata[87:64]);
            mismatches++;
        end
        if (o_m_axis_tlast !== want.tile_last) begin
            $error("tile_last: expected %b, got %b", want.tile_last, o_m_axis_tlast);
            mismatches++;
        end
        if (o_m_axis_tuser !== want.frame_last) begin
            $error("frame_last: expected %b, got %b", want.frame_last, o_m_axis_tuser);
            mismatches++;
        end
    endfunction

    // Both sides sampled at the rising edge, before the core's own updates land.
    always @(posedge i_clk) begin
        row_fire = i_rst_n && i_s_axis_tvalid && o_s_axis_tready;
        if (row_fire) take_source_row(i_s_axis_tdata);
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) check_rotated_row();
    end

    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d rows still expected",
                     cycle_cnt, rotated_q.size());
            $display("CHECK FAILED");
            $finish;
        end
    end

    // Source: bursts of random length, random gaps between them (a third with none).
    // An open offer is never withdrawn before its transfer.
    initial begin : row_source
        int burst_left;
        int gap_left;
        burst_left      = $urandom_range(1, 16);
        gap_left        = 0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata  = '0;
        forever begin
            @(negedge i_clk);
            if (row_fire) begin
                void'(source_q.pop_front());
                burst_left--;
                if (burst_left == 0) begin
                    burst_left = $urandom_range(1, 24);
                    gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                end
            end
            if (!i_s_axis_tvalid || row_fire) begin
                if (gap_left > 0) begin
                    gap_left--;
                    i_s_axis_tvalid <= 1'b0;
                end else if (source_q.size() > 0) begin
                    i_s_axis_tvalid <= 1'b1;
                    i_s_axis_tdata  <= source_q[0];
                end else begin
                    i_s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Sink: an 8-slot ready pattern, redrawn at every 64th slot (sometimes always ready),
    // plus one long hold-off on request so the core fills and stalls its input.
    initial begin : row_sink
        int          hold_left;
        int          slot;
        logic [7:0]  ready_mask;
        hold_left       = 0;
        slot            = 0;
        ready_mask      = 8'hFF;
        i_m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (long_hold_req) begin
                long_hold_req = 1'b0;
                hold_left     = HOLD_CYCLES;
            end
            if (slot % 64 == 0) begin
                case ($urandom_range(0, 3))
                    0:       ready_mask = 8'hFF;
                    1:       ready_mask = 8'($urandom);
                    2:       ready_mask = 8'b1011_0110;
                    default: ready_mask = 8'($urandom) | 8'h81;
                endcase
            end
            if (hold_left > 0) begin
                hold_left--;
                i_m_axis_tready <= 1'b0;
            end else begin
                i_m_axis_tready <= ready_mask[slot % 8];
            end
            slot++;
        end
    end

    // All three registers plus a write to the unused index, then the golden copy follows.
    task automatic set_geometry(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h,
                                input logic d);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= CFG_DST_WIDTH;
        i_cfg_wdata <= w;
        @(negedge i_clk);
        i_cfg_addr  <= CFG_DEST_HEIGHT;
        i_cfg_wdata <= h;
        @(negedge i_clk);
        i_cfg_addr  <= CFG_TURN_DIR;
        i_cfg_wdata <= {(CFG_W-1)'($urandom), d};  // upper bits are don't-care
        @(negedge i_clk);
        i_cfg_addr  <= CFG_SPARE;
        i_cfg_wdata <= CFG_W'($urandom);
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        geo_width  = w;
        geo_height = h;
        geo_dir    = d;
    endtask

    // Wait until every row is sent and every predicted row has come out, then settle.
    task automatic drain();
        while (source_q.size() != 0 || rotated_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    function automatic logic [DATA_W-1:0] random_row();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    function automatic logic [DATA_W-1:0] directed_row(input t_fill f, input int r);
        case (f)
            FILL_ZERO: return '0;
            FILL_ONES: return '1;
            FILL_RAMP: return 64'h0706_0504_0302_0100 + 64'(r) * 64'h1010_1010_1010_1010;
            default:   return random_row();
        endcase
    endfunction

    // Mostly small planes (1..4 tiles a side, sometimes with stray low bits),
    // now and then zero, all ones, exactly MAX_SIDE or any 13-bit value.
    function automatic logic [CFG_W-1:0] pick_side();
        case ($urandom_range(0, 15))
            0:       return '0;
            1:       return '1;
            2:       return 13'd4096;
            3:       return CFG_W'($urandom);
            default: return CFG_W'(8 * $urandom_range(1, 4) +
                                   (($urandom_range(0, 3) == 0) ? $urandom_range(1, 7) : 0));
        endcase
    endfunction

    initial begin : stimulus
        int random_rows;
        int n;
        bit first;
        i_rst_n     = 1'b0;
        i_cfg_we    = 1'b0;
        i_cfg_addr  = '0;
        i_cfg_wdata = '0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed opening
        foreach (OPENING_RUNS[p]) begin
            if (OPENING_RUNS[p].set_geo) begin
                set_geometry(OPENING_RUNS[p].width, OPENING_RUNS[p].height,
                             OPENING_RUNS[p].dir);
            end
            pinned_en         = OPENING_RUNS[p].pinned;
            pinned_pix        = OPENING_RUNS[p].pin_pix;
            pinned_base       = OPENING_RUNS[p].pin_base;
            pinned_step       = OPENING_RUNS[p].pin_step;
            pinned_frame_last = OPENING_RUNS[p].pin_frame_last;
            for (int r = 0; r < OPENING_RUNS[p].rows; r++) begin
                source_q.push_back(directed_row(OPENING_RUNS[p].fill, r));
            end
            drain();
            pinned_en = 1'b0;
        end

        // Random runs: mostly whole tiles, sometimes a ragged count that leaves a
        // tile half full across the next geometry change. The first run is long and
        // meets the sink hold-off.
        random_rows = 0;
        first       = 1'b1;
        while (random_rows < RANDOM_ROWS) begin
            if (first || $urandom_range(0, 3) != 0) begin
                set_geometry(pick_side(), pick_side(), 1'($urandom_range(0, 1)));
            end
            if (first) begin
                n             = 48;
                long_hold_req = 1'b1;
            end else if ($urandom_range(0, 4) != 0) begin
                n = 8 * $urandom_range(1, 6);
            end else begin
                n = $urandom_range(1, 20);
            end
            first = 1'b0;
            repeat (n) source_q.push_back(random_row());
            random_rows += n;
            drain();
        end

        repeat (20) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

@@ sim.f @@
sv/tpr90_pkg.sv
sv/tpr90_emit.sv
sv/tiled_plane_rotate_90_core.sv
tb/tb_tiled_plane_rotate_90_core.sv
